// ----- hw/rtl/mslfo_pkg.sv -----
`timescale 1ns / 1ps
// mslfo_pkg: shared types, constants and functions of the multi-shape lfo
// used by every module of the block; depends on nothing

package mslfo_pkg;

	localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
	localparam int unsigned PHASE_BITS_DEF       = 32;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned SAMPLE_W    = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SHAPE      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RETRIGGER       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_INCREMENT = 2'd2;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] TAYLOR_DIV [1:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

	typedef enum logic [2:0] {
		SHAPE_SINE     = 3'd0,
		SHAPE_TRIANGLE = 3'd1,
		SHAPE_SAW      = 3'd2,
		SHAPE_SQUARE   = 3'd3,
		SHAPE_HOLD     = 3'd4
	} shape_t;

	typedef struct packed {
		shape_t      shape;
		logic        retrig;
		logic [31:0] inc;
	} cfg_t;

	typedef struct packed {
		logic                       use_sine;
		logic signed [SAMPLE_W-1:0] raw;
		logic [15:0]                p16;
	} wave_t;

	function automatic logic signed [SAMPLE_W-1:0] sat18(input logic signed [17:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	// sin(pi/2 * u), u in q30, as q1.15; taylor series through the 11th power
	function automatic logic [15:0] quarter_sine(input logic [63:0] u);
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		a    = (u * HALF_PI_Q30) >> 30;
		a2   = (a * a) >> 30;
		term = a;
		sum  = a;
		for (int k = 1; k <= 5; k++) begin
			term = ((term * a2) >> 30) / TAYLOR_DIV[k];
			if (k % 2 == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage

// ----- hw/rtl/mslfo_sine_rom.sv -----
`timescale 1ns / 1ps
// mslfo_sine_rom: full-cycle sine table with registered read
// contents built at elaboration; depends on mslfo_pkg

module mslfo_sine_rom
	import mslfo_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [IDX_W-1:0]           idx,
	output logic signed [SAMPLE_W-1:0] data
);

	typedef logic signed [SAMPLE_W-1:0] rom_t [SINE_TABLE_DEPTH];

	function automatic rom_t fill_rom();
		rom_t        r;
		logic [63:0] t;
		logic [63:0] u;
		logic [1:0]  q;
		logic [15:0] s;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			t = (64'(i) << 32) / SINE_TABLE_DEPTH;
			q = t[31:30];
			u = {34'd0, t[29:0]};
			if (q[0]) begin
				u = ONE_Q30 - u;
			end
			s = quarter_sine(u);
			r[i] = q[1] ? -$signed(s) : $signed(s);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = fill_rom();

	logic signed [SAMPLE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= SINE_ROM[idx];
		end
	end

	assign data = data_q;

endmodule

// ----- hw/rtl/mslfo_phase.sv -----
`timescale 1ns / 1ps
// mslfo_phase: phase accumulator, sample-and-hold state and non-table shapes
// depends on mslfo_pkg

module mslfo_phase
	import mslfo_pkg::*;
#(
	parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  logic  note_on,
	input  cfg_t  cfg,
	output wave_t wave
);

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS:0]   prev_q;
	logic signed [15:0]    held_q;

	logic                  retrig;
	logic [PHASE_BITS-1:0] phase_eff;
	logic [PHASE_BITS:0]   prev_eff;
	logic [PHASE_BITS-1:0] inc_al;
	logic [15:0]           p16;
	logic                  hold_upd;
	logic signed [24:0]    h134;
	logic signed [24:0]    hsum;
	logic [47:0]           div_prod;
	logic [15:0]           div_q;
	logic signed [15:0]    held_new;
	logic signed [17:0]    tri_v;
	logic signed [15:0]    raw;

	assign retrig    = note_on & cfg.retrig;
	assign phase_eff = retrig ? '0 : phase_q;
	assign prev_eff  = retrig ? {1'b1, {PHASE_BITS{1'b0}}} : prev_q;
	assign p16       = phase_eff[PHASE_BITS-1 -: 16];
	assign hold_upd  = {1'b0, phase_eff} < prev_eff;

	generate
		if (PHASE_BITS >= 32) begin : g_inc_up
			assign inc_al = PHASE_BITS'(cfg.inc) << (PHASE_BITS - 32);
		end else begin : g_inc_dn
			assign inc_al = PHASE_BITS'(cfg.inc >> (32 - PHASE_BITS));
		end
	endgenerate

	// held*134 + offset stays positive below 2^24; /10 by reciprocal
	assign h134     = (25'(held_q) <<< 7) + (25'(held_q) <<< 2) + (25'(held_q) <<< 1);
	assign hsum     = h134 + 25'sd6979584;
	assign div_prod = 48'(hsum[23:0]) * 48'hCCCCCD;
	assign div_q    = div_prod[42:27];
	assign held_new = $signed({~div_q[15], div_q[14:0]});

	always_comb begin
		tri_v = '0;
		raw   = '0;
		case (cfg.shape)
			SHAPE_SINE: begin
				raw = '0;
			end
			SHAPE_TRIANGLE: begin
				if (!p16[15]) begin
					tri_v = $signed({1'b0, p16, 1'b0}) - 18'sd32768;
				end else begin
					tri_v = 18'sd98304 - $signed({1'b0, p16, 1'b0});
				end
				raw = sat18(tri_v);
			end
			SHAPE_SAW: begin
				raw = $signed({~p16[15], p16[14:0]});
			end
			SHAPE_SQUARE: begin
				raw = p16[15] ? 16'sh8000 : 16'sh7fff;
			end
			SHAPE_HOLD: begin
				raw = hold_upd ? held_new : held_q;
			end
			default: begin
				raw = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			prev_q  <= {1'b1, {PHASE_BITS{1'b0}}};
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_eff + inc_al;
			if (cfg.shape == SHAPE_HOLD) begin
				prev_q <= {1'b0, phase_eff};
				if (hold_upd) begin
					held_q <= held_new;
				end
			end else begin
				prev_q <= prev_eff;
			end
		end
	end

	assign wave.use_sine = (cfg.shape == SHAPE_SINE);
	assign wave.raw      = raw;
	assign wave.p16      = p16;

endmodule

// ----- hw/rtl/mslfo_scale.sv -----
`timescale 1ns / 1ps
// mslfo_scale: waveform times depth, rounded half up, saturated to q1.15
// depends on mslfo_pkg

module mslfo_scale
	import mslfo_pkg::*;
(
	input  logic signed [SAMPLE_W-1:0] raw,
	input  logic signed [SAMPLE_W-1:0] depth,
	output logic signed [SAMPLE_W-1:0] value
);

	logic signed [31:0] prod;
	logic signed [32:0] rnd;

	assign prod  = raw * depth;
	assign rnd   = 33'(prod) + 33'sd16384;
	assign value = sat18(rnd[32:15]);

endmodule

// ----- hw/rtl/multi_shape_lfo_unit.sv -----
`timescale 1ns / 1ps
// multi_shape_lfo_unit: top level of the multi-shape lfo
// depends on mslfo_pkg, mslfo_phase, mslfo_sine_rom, mslfo_scale

// One transaction in gives one lfo sample out. The unit takes a new sample every
// cycle unless m_tready stalls the output. Each result passes through one
// stage for the registered sine table read and the phase update, then one for the
// depth multiply and saturation. Phase and sample-and-hold state advance when the
// input transaction is taken, so back-to-back samples see each other's state.
// Write configuration only while no sample is in flight. The sine table is
// built at elaboration and needs no startup pass.

module multi_shape_lfo_unit
	import mslfo_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int unsigned PHASE_BITS       = PHASE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [23:0]            s_tdata,   // note_on, depth[15:0], zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // lfo_value[15:0]
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);

	cfg_t  cfg_q;
	wave_t wave;

	logic                       s_accept;
	logic                       adv_out;
	logic                       valid_s1;
	logic                       use_sine_s1;
	logic signed [SAMPLE_W-1:0] raw_s1;
	logic signed [SAMPLE_W-1:0] depth_s1;
	logic signed [SAMPLE_W-1:0] sine_s1;
	logic signed [SAMPLE_W-1:0] raw_sel;
	logic signed [SAMPLE_W-1:0] value;
	logic [32:0]                idx_prod;
	logic [IDX_W-1:0]           idx;
	logic                       out_valid_q;
	logic [15:0]                out_q;

	assign adv_out  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv_out;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape  <= SHAPE_SINE;
			cfg_q.retrig <= 1'b0;
			cfg_q.inc    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WAVE_SHAPE:      cfg_q.shape  <= shape_t'(cfg_data[2:0]);
				CFG_RETRIGGER:       cfg_q.retrig <= cfg_data[0];
				CFG_PHASE_INCREMENT: cfg_q.inc    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mslfo_phase #(
		.PHASE_BITS(PHASE_BITS)
	) u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (s_accept),
		.note_on(s_tdata[0]),
		.cfg    (cfg_q),
		.wave   (wave)
	);

	assign idx_prod = 33'(wave.p16) * 33'(SINE_TABLE_DEPTH);
	assign idx      = idx_prod[16 +: IDX_W];

	mslfo_sine_rom #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_sine_rom (
		.clk (clk),
		.en  (s_accept),
		.idx (idx),
		.data(sine_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			use_sine_s1 <= wave.use_sine;
			raw_s1      <= wave.raw;
			depth_s1    <= $signed(s_tdata[16:1]);
		end
	end

	assign raw_sel = use_sine_s1 ? sine_s1 : raw_s1;

	mslfo_scale u_scale (
		.raw  (raw_sel),
		.depth(depth_s1),
		.value(value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_q <= value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> valid_s1)
		else $error("accepted transaction did not reach stage one");

	a_s1_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_out) |=> m_tvalid)
		else $error("stage one sample lost on its way out");

	a_zero_depth_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_out && depth_s1 == 16'sd0) |=> m_tdata == 16'd0)
		else $error("zero depth gave a nonzero sample");

endmodule
